@@ rtl/tlc_pkg.sv @@
// Shared types, constants and helpers for the tensor layout checker.
package tlc_pkg;

   localparam int MAX_DIMS = 8;
   localparam int IDX_W    = $clog2(MAX_DIMS);
   localparam int CNT_W    = $clog2(MAX_DIMS + 1);

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_RANK   = 3'd1;
   localparam logic [2:0] ST_BAD_DTYPE  = 3'd2;
   localparam logic [2:0] ST_ZERO_EXT   = 3'd3;
   localparam logic [2:0] ST_SHAPE_OVF  = 3'd4;
   localparam logic [2:0] ST_BYTE_OVF   = 3'd5;
   localparam logic [2:0] ST_BAD_STRIDE = 3'd6;

   localparam logic [2:0] DT_F32  = 3'd0;
   localparam logic [2:0] DT_F16  = 3'd1;
   localparam logic [2:0] DT_BF16 = 3'd2;
   localparam logic [2:0] DT_I8   = 3'd3;
   localparam logic [2:0] DT_I32  = 3'd4;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             rank_exceeded;
      logic [2:0]       dtype;
      logic             strides_mode;
   } job_type;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic        ovf;
      logic [63:0] res;
   } mul_rsp_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] elem_total;
      logic [63:0] byte_total;
      logic [63:0] span_bytes;
      logic        contiguous;
      logic [2:0]  dim_index;
      logic [63:0] out_stride;
      logic        last_result;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_FWD_CHK, S_FWD_MUL, S_BYTES_GO, S_BYTES_MUL, S_BWD_CHK, S_BWD_MUL,
      S_SPAN_GO, S_SPAN_MUL, S_SPAN_END, S_EMIT, S_ERR
   } state_type;

   function automatic logic [2:0] elem_size(input logic [2:0] code);
      case (code)
         DT_F32, DT_I32:  elem_size = 3'd4;
         DT_F16, DT_BF16: elem_size = 3'd2;
         DT_I8:           elem_size = 3'd1;
         default:         elem_size = 3'd0;
      endcase
   endfunction

endpackage

@@ rtl/tlc_front.sv @@
// Front end: takes dimension items into two banks of stores and queues closed descriptors.
module tlc_front import tlc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [63:0]       req_dim_extent,
   input  logic [63:0]       req_dim_stride,
   input  logic              req_strides_given,
   input  logic [2:0]        req_dtype_code,
   input  logic              req_last_dim,
   output logic              job_valid,
   output job_type           job,
   input  logic              job_pop,
   input  logic [IDX_W-1:0]  rd_idx,
   output logic [63:0]       rd_ext,
   output logic [63:0]       rd_stride
);

   logic [63:0]      ext_ff [2*MAX_DIMS];
   logic [63:0]      str_ff [2*MAX_DIMS];
   logic [CNT_W-1:0] dims_ff, dims_in;
   logic             rexc_ff, rexc_in;
   logic [2:0]       dtype_ff, dtype_in;
   logic             mode_ff, mode_in;
   job_type          jq_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       jcnt_ff, jcnt_in;
   logic             accept, first, room, push_job;
   job_type          new_job;

   assign req_full  = (jcnt_ff == 2'd2);
   assign accept    = req_push && !req_full;
   assign first     = (dims_ff == '0) && !rexc_ff;
   assign room      = (dims_ff < CNT_W'(MAX_DIMS));
   assign push_job  = accept && req_last_dim;
   assign job_valid = (jcnt_ff != 2'd0);
   assign job       = jq_ff[rd_ptr_ff];
   assign rd_ext    = ext_ff[{rd_ptr_ff, rd_idx}];
   assign rd_stride = str_ff[{rd_ptr_ff, rd_idx}];

   always_comb begin
      dtype_in = first ? req_dtype_code : dtype_ff;
      mode_in  = first ? req_strides_given : mode_ff;
      new_job.count         = room ? dims_ff + CNT_W'(1) : dims_ff;
      new_job.rank_exceeded = rexc_ff || !room;
      new_job.dtype         = dtype_in;
      new_job.strides_mode  = mode_in;
      dims_in = dims_ff;
      rexc_in = rexc_ff;
      if (accept) begin
         if (req_last_dim) begin
            dims_in = '0;
            rexc_in = 1'b0;
         end else if (room) begin
            dims_in = dims_ff + CNT_W'(1);
         end else begin
            rexc_in = 1'b1;
         end
      end
      jcnt_in = jcnt_ff + {1'b0, push_job} - {1'b0, job_pop};
   end

   always_ff @(posedge clock) begin
      if (accept && room) begin
         ext_ff[{wr_ptr_ff, dims_ff[IDX_W-1:0]}] <= req_dim_extent;
         str_ff[{wr_ptr_ff, dims_ff[IDX_W-1:0]}] <= req_dim_stride;
      end
      if (push_job) jq_ff[wr_ptr_ff] <= new_job;
      if (reset) begin
         dims_ff   <= '0;
         rexc_ff   <= 1'b0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         jcnt_ff   <= 2'd0;
         dtype_ff  <= '0;
         mode_ff   <= 1'b0;
      end else begin
         dims_ff <= dims_in;
         rexc_ff <= rexc_in;
         jcnt_ff <= jcnt_in;
         if (accept) begin
            dtype_ff <= dtype_in;
            mode_ff  <= mode_in;
         end
         if (push_job) wr_ptr_ff <= !wr_ptr_ff;
         if (job_pop) rd_ptr_ff <= !rd_ptr_ff;
      end
   end

endmodule

@@ rtl/tlc_mul.sv @@
// Multicycle 64 by 64 checked multiplier built from four 32 by 32 partial products.
module tlc_mul import tlc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   logic [63:0] a_ff, b_ff, prod_ff, lo_ff, res_ff;
   logic [32:0] mid_ff;
   logic [2:0]  step_ff;
   logic        busy_ff, done_ff, ovf_ff;
   logic [31:0] a_sel, b_sel;
   logic [64:0] sum;

   assign a_sel = step_ff[0] ? a_ff[63:32] : a_ff[31:0];
   assign b_sel = step_ff[1] ? b_ff[63:32] : b_ff[31:0];
   assign sum   = {1'b0, lo_ff} + {1'b0, mid_ff[31:0], 32'd0};

   assign rsp.done = done_ff;
   assign rsp.ovf  = ovf_ff;
   assign rsp.res  = res_ff;

   always_ff @(posedge clock) begin
      prod_ff <= a_sel * b_sel;
      if (req.start) begin
         a_ff   <= req.a;
         b_ff   <= req.b;
         ovf_ff <= 1'b0;
      end else if (busy_ff) begin
         case (step_ff)
            3'd1: lo_ff <= prod_ff;
            3'd2: begin
               mid_ff <= {1'b0, prod_ff[31:0]};
               if (prod_ff[63:32] != '0) ovf_ff <= 1'b1;
            end
            3'd3: begin
               mid_ff <= mid_ff + {1'b0, prod_ff[31:0]};
               if (prod_ff[63:32] != '0) ovf_ff <= 1'b1;
            end
            3'd4: begin
               res_ff <= sum[63:0];
               if (prod_ff != '0 || mid_ff[32] || sum[64]) ovf_ff <= 1'b1;
            end
            default: ;
         endcase
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= busy_ff && (step_ff == 3'd4);
         if (req.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 3'd1;
            if (step_ff == 3'd4) busy_ff <= 1'b0;
         end
      end
   end

endmodule

@@ rtl/tlc_back.sv @@
// Back end: sequencer that runs the shape, stride and span checks and emits results.
module tlc_back import tlc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  job_type          job,
   output logic             job_pop,
   output logic [IDX_W-1:0] rd_idx,
   input  logic [63:0]      rd_ext,
   input  logic [63:0]      rd_stride,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             rsp_pop
);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff;
   logic [63:0]      elems_ff, bytes_ff, expect_ff, maxoff_ff, span_ff;
   logic [63:0]      strides_ff [MAX_DIMS];
   logic             contig_ff;
   logic [2:0]       err_ff;
   logic             valid_ff;
   rsp_type          out_ff;

   mul_req_type      mreq;
   mul_rsp_type      mrsp;
   logic [63:0]      esz, cur_stride;
   logic [IDX_W-1:0] last_idx;
   logic             at_last, slot_free, bad_stride, err_set, out_wr;
   logic [2:0]       err_code;
   logic [64:0]      span_sum, end_sum;
   rsp_type          out_data;

   tlc_mul u_mul (.clock(clock), .reset(reset), .req(mreq), .rsp(mrsp));

   assign esz        = {61'd0, elem_size(job.dtype)};
   assign last_idx   = IDX_W'(job.count - CNT_W'(1));
   assign at_last    = (idx_ff == last_idx);
   assign rd_idx     = idx_ff;
   assign slot_free  = !valid_ff || rsp_pop;
   assign cur_stride = job.strides_mode ? rd_stride : expect_ff;
   assign bad_stride = ((rd_ext > 64'd1) && (rd_stride == '0))
                       || ((rd_stride & (esz - 64'd1)) != '0);
   assign span_sum   = {1'b0, maxoff_ff} + {1'b0, mrsp.res};
   assign end_sum    = {1'b0, maxoff_ff} + {1'b0, esz};
   assign rsp_valid  = valid_ff;
   assign rsp_data   = out_ff;

   // control outputs
   always_comb begin
      mreq     = '{start: 1'b0, a: elems_ff, b: rd_ext};
      err_set  = 1'b0;
      err_code = ST_OK;
      job_pop  = 1'b0;
      out_wr   = 1'b0;
      out_data = '0;
      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               if (job.rank_exceeded || job.count == '0) begin
                  err_set  = 1'b1;
                  err_code = ST_BAD_RANK;
               end else if (esz == '0) begin
                  err_set  = 1'b1;
                  err_code = ST_BAD_DTYPE;
               end
            end
         end
         S_FWD_CHK: begin
            if (rd_ext == '0) begin
               err_set  = 1'b1;
               err_code = ST_ZERO_EXT;
            end else begin
               mreq.start = 1'b1;
            end
         end
         S_FWD_MUL: begin
            if (mrsp.done && mrsp.ovf) begin
               err_set  = 1'b1;
               err_code = ST_SHAPE_OVF;
            end
         end
         S_BYTES_GO: begin
            mreq.start = 1'b1;
            mreq.b     = esz;
         end
         S_BYTES_MUL, S_BWD_MUL: begin
            if (mrsp.done && mrsp.ovf) begin
               err_set  = 1'b1;
               err_code = ST_BYTE_OVF;
            end
         end
         S_BWD_CHK: begin
            if (job.strides_mode && bad_stride) begin
               err_set  = 1'b1;
               err_code = ST_BAD_STRIDE;
            end else begin
               mreq.start = 1'b1;
               mreq.a     = expect_ff;
            end
         end
         S_SPAN_GO: begin
            mreq.start = 1'b1;
            mreq.a     = rd_ext - 64'd1;
            mreq.b     = strides_ff[idx_ff];
         end
         S_SPAN_MUL: begin
            if (mrsp.done && (mrsp.ovf || span_sum[64])) begin
               err_set  = 1'b1;
               err_code = ST_BYTE_OVF;
            end
         end
         S_SPAN_END: begin
            if (end_sum[64]) begin
               err_set  = 1'b1;
               err_code = ST_BYTE_OVF;
            end
         end
         S_EMIT: begin
            out_data.status      = ST_OK;
            out_data.elem_total  = elems_ff;
            out_data.byte_total  = bytes_ff;
            out_data.span_bytes  = span_ff;
            out_data.contiguous  = contig_ff;
            out_data.dim_index   = 3'(idx_ff);
            out_data.out_stride  = strides_ff[idx_ff];
            out_data.last_result = at_last;
            out_wr  = slot_free;
            job_pop = slot_free && at_last;
         end
         S_ERR: begin
            out_data.status      = err_ff;
            out_data.last_result = 1'b1;
            out_wr  = slot_free;
            job_pop = slot_free;
         end
         default: ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      if (err_set) begin
         state_in = S_ERR;
      end else begin
         case (state_ff)
            S_IDLE:      if (job_valid) state_in = S_FWD_CHK;
            S_FWD_CHK:   state_in = S_FWD_MUL;
            S_FWD_MUL:   if (mrsp.done) state_in = at_last ? S_BYTES_GO : S_FWD_CHK;
            S_BYTES_GO:  state_in = S_BYTES_MUL;
            S_BYTES_MUL: if (mrsp.done) state_in = S_BWD_CHK;
            S_BWD_CHK:   state_in = S_BWD_MUL;
            S_BWD_MUL: begin
               if (mrsp.done) begin
                  if (idx_ff != '0) state_in = S_BWD_CHK;
                  else state_in = job.strides_mode ? S_SPAN_GO : S_EMIT;
               end
            end
            S_SPAN_GO:   state_in = S_SPAN_MUL;
            S_SPAN_MUL:  if (mrsp.done) state_in = at_last ? S_SPAN_END : S_SPAN_GO;
            S_SPAN_END:  state_in = S_EMIT;
            S_EMIT:      if (slot_free && at_last) state_in = S_IDLE;
            S_ERR:       if (slot_free) state_in = S_IDLE;
            default:     state_in = S_IDLE;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (err_set) err_ff <= err_code;
      case (state_ff)
         S_IDLE: begin
            idx_ff   <= '0;
            elems_ff <= 64'd1;
         end
         S_FWD_MUL: begin
            if (mrsp.done) begin
               elems_ff <= mrsp.res;
               if (!at_last) idx_ff <= idx_ff + IDX_W'(1);
            end
         end
         S_BYTES_MUL: begin
            bytes_ff  <= mrsp.res;
            expect_ff <= esz;
            contig_ff <= 1'b1;
            idx_ff    <= last_idx;
         end
         S_BWD_CHK: begin
            strides_ff[idx_ff] <= cur_stride;
            if (cur_stride != expect_ff) contig_ff <= 1'b0;
         end
         S_BWD_MUL: begin
            if (mrsp.done) begin
               expect_ff <= mrsp.res;
               span_ff   <= mrsp.res;
               maxoff_ff <= '0;
               if (idx_ff != '0) idx_ff <= idx_ff - IDX_W'(1);
            end
         end
         S_SPAN_MUL: begin
            if (mrsp.done) begin
               maxoff_ff <= span_sum[63:0];
               if (!at_last) idx_ff <= idx_ff + IDX_W'(1);
            end
         end
         S_SPAN_END: begin
            span_ff <= end_sum[63:0];
            idx_ff  <= '0;
         end
         S_EMIT: if (slot_free && !at_last) idx_ff <= idx_ff + IDX_W'(1);
         default: ;
      endcase
      if (out_wr) out_ff <= out_data;
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_wr) valid_ff <= 1'b1;
         else if (rsp_pop) valid_ff <= 1'b0;
      end
   end

endmodule

@@ rtl/tensor_layout_checker.sv @@
// Top level of the tensor layout checker: front end, descriptor queue and check sequencer.
//
//   channel   direction  handshake        transfer when
//   req_*     in         push / full      push && !full
//   rsp_*     out        empty / pop      pop && !empty
//
// Dimension items enter while req_full is low; up to two closed descriptors are held in the
// front queue, the one under check included, each with its own bank of extent and stride stores.
// For each dimension and pass the back end starts a multiply and then waits on the shared 64 by 64
// multiplier built from 32x32 partial products; explicit strides add a span pass, and errors leave
// after the failing step.
// Reset is synchronous and clears the queue, sequencer and output valid flag.
// A stalled result holds the back end; the front keeps taking items until its queue fills.
module tensor_layout_checker import tlc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [63:0] req_dim_extent,
   input  logic [63:0] req_dim_stride,
   input  logic        req_strides_given,
   input  logic [2:0]  req_dtype_code,
   input  logic        req_last_dim,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_elem_total,
   output logic [63:0] rsp_byte_total,
   output logic [63:0] rsp_span_bytes,
   output logic        rsp_contiguous,
   output logic [2:0]  rsp_dim_index,
   output logic [63:0] rsp_out_stride,
   output logic        rsp_last_result
);

   logic             job_valid, job_pop, rsp_valid;
   job_type          job;
   logic [IDX_W-1:0] rd_idx;
   logic [63:0]      rd_ext, rd_stride;
   rsp_type          rsp_data;

   tlc_front u_front (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_dim_extent(req_dim_extent), .req_dim_stride(req_dim_stride),
      .req_strides_given(req_strides_given), .req_dtype_code(req_dtype_code),
      .req_last_dim(req_last_dim),
      .job_valid(job_valid), .job(job), .job_pop(job_pop),
      .rd_idx(rd_idx), .rd_ext(rd_ext), .rd_stride(rd_stride)
   );

   tlc_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(job_valid), .job(job), .job_pop(job_pop),
      .rd_idx(rd_idx), .rd_ext(rd_ext), .rd_stride(rd_stride),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .rsp_pop(rsp_pop)
   );

   assign rsp_empty       = !rsp_valid;
   assign rsp_status      = rsp_data.status;
   assign rsp_elem_total  = rsp_data.elem_total;
   assign rsp_byte_total  = rsp_data.byte_total;
   assign rsp_span_bytes  = rsp_data.span_bytes;
   assign rsp_contiguous  = rsp_data.contiguous;
   assign rsp_dim_index   = rsp_data.dim_index;
   assign rsp_out_stride  = rsp_data.out_stride;
   assign rsp_last_result = rsp_data.last_result;

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not cleared by reset");

   a_err_single: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != ST_OK) |->
         (rsp_last_result && rsp_dim_index == 3'd0 && rsp_elem_total == '0))
      else $error("error result is not a single cleared result");

   a_pop_needs_job: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> job_valid)
      else $error("descriptor released with none queued");

endmodule

@@ tb/tensor_layout_checker_scoreboard.sv @@
// Scoreboard for the tensor layout checker: predicts descriptor checks and compares results.
`timescale 1ns / 1ps
module tensor_layout_checker_scoreboard import tlc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [63:0] req_dim_extent,
   input  logic [63:0] req_dim_stride,
   input  logic        req_strides_given,
   input  logic [2:0]  req_dtype_code,
   input  logic        req_last_dim,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [2:0]  rsp_status,
   input  logic [63:0] rsp_elem_total,
   input  logic [63:0] rsp_byte_total,
   input  logic [63:0] rsp_span_bytes,
   input  logic        rsp_contiguous,
   input  logic [2:0]  rsp_dim_index,
   input  logic [63:0] rsp_out_stride,
   input  logic        rsp_last_result,
   output int          fail_count,
   output int          pending_count
);
   localparam logic [63:0] ALL_ONES = '1;

   logic [63:0] extents [MAX_DIMS];
   logic [63:0] strides_in [MAX_DIMS];
   int          loaded;
   bit          overrun;
   logic [2:0]  dtype_held;
   bit          explicit_held;
   rsp_type     layout_queue [$];

   function automatic bit mul_fits(input logic [63:0] a, input logic [63:0] b,
                                   output logic [63:0] r);
      logic [127:0] p;
      p = a * b;
      r = p[63:0];
      return p[127:64] == 0;
   endfunction

   function automatic bit add_fits(input logic [63:0] a, input logic [63:0] b,
                                   output logic [63:0] r);
      r = a + b;
      return a <= ALL_ONES - b;
   endfunction

   task automatic push_error(input logic [2:0] st);
      rsp_type e;
      e = '0;
      e.status = st;
      e.last_result = 1'b1;
      layout_queue.push_back(e);
   endtask

   task automatic predict_layout();
      logic [63:0] esz, elems, nbytes, canon, span, maxoff, contrib, s;
      logic [63:0] dim_strides [MAX_DIMS];
      bit contig;
      rsp_type e;
      elems = 1; maxoff = 0; contig = 1;
      if (overrun || loaded == 0) begin
         push_error(ST_BAD_RANK); return;
      end
      case (dtype_held)
         DT_F32, DT_I32: esz = 4;
         DT_F16, DT_BF16: esz = 2;
         DT_I8: esz = 1;
         default: esz = 0;
      endcase
      if (esz == 0) begin
         push_error(ST_BAD_DTYPE); return;
      end
      for (int i = 0; i < loaded; i++) begin
         if (extents[i] == 0) begin
            push_error(ST_ZERO_EXT); return;
         end
         if (!mul_fits(elems, extents[i], elems)) begin
            push_error(ST_SHAPE_OVF); return;
         end
      end
      if (!mul_fits(elems, esz, nbytes)) begin
         push_error(ST_BYTE_OVF); return;
      end
      canon = esz;
      for (int i = loaded - 1; i >= 0; i--) begin
         if (explicit_held) begin
            s = strides_in[i];
            if ((extents[i] > 1 && s == 0) || (s % esz) != 0) begin
               push_error(ST_BAD_STRIDE); return;
            end
            if (s != canon) contig = 0;
            dim_strides[i] = s;
         end else begin
            dim_strides[i] = canon;
         end
         if (!mul_fits(canon, extents[i], canon)) begin
            push_error(ST_BYTE_OVF); return;
         end
      end
      span = canon;
      if (explicit_held) begin
         for (int i = 0; i < loaded; i++) begin
            if (!mul_fits(extents[i] - 64'd1, dim_strides[i], contrib) ||
                !add_fits(maxoff, contrib, maxoff)) begin
               push_error(ST_BYTE_OVF); return;
            end
         end
         if (!add_fits(maxoff, esz, span)) begin
            push_error(ST_BYTE_OVF); return;
         end
      end
      for (int i = 0; i < loaded; i++) begin
         e.status = ST_OK;
         e.elem_total = elems;
         e.byte_total = nbytes;
         e.span_bytes = span;
         e.contiguous = contig;
         e.dim_index = i[2:0];
         e.out_stride = dim_strides[i];
         e.last_result = (i == loaded - 1);
         layout_queue.push_back(e);
      end
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch expected %h actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type w;
      if (reset) begin
         overrun = 0; dtype_held = 0; explicit_held = 0;
         loaded = 0;
         fail_count = 0;
         layout_queue.delete();
      end else begin
         if (req_push && !req_full) begin
            if (loaded == 0 && !overrun) begin
               dtype_held = req_dtype_code;
               explicit_held = req_strides_given;
            end
            if (loaded < MAX_DIMS) begin
               extents[loaded] = req_dim_extent;
               strides_in[loaded] = req_dim_stride;
               loaded = loaded + 1;
            end else overrun = 1;
            if (req_last_dim) begin
               predict_layout();
               loaded = 0; overrun = 0;
            end
         end
         if (rsp_pop && !rsp_empty) begin
            if (layout_queue.size() == 0) begin
               $display("%0t: unexpected result status %0d", $time, rsp_status);
               fail_count++;
            end else begin
               w = layout_queue.pop_front();
               compare_field("status", w.status, rsp_status);
               compare_field("elem_total", w.elem_total, rsp_elem_total);
               compare_field("byte_total", w.byte_total, rsp_byte_total);
               compare_field("span_bytes", w.span_bytes, rsp_span_bytes);
               compare_field("contiguous", w.contiguous, rsp_contiguous);
               compare_field("dim_index", w.dim_index, rsp_dim_index);
               compare_field("out_stride", w.out_stride, rsp_out_stride);
               compare_field("last_result", w.last_result, rsp_last_result);
            end
         end
      end
      pending_count = layout_queue.size();
   end
endmodule

@@ tb/tensor_layout_checker_tb.sv @@
// Top of the tensor layout checker testbench: clock, reset, descriptor stimulus and verdict.
`timescale 1ns / 1ps
module tensor_layout_checker_tb import tlc_pkg::*;;

   localparam int IDLE_LIMIT = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_push = 0;
   logic        req_full;
   logic [63:0] req_dim_extent = 0;
   logic [63:0] req_dim_stride = 0;
   logic        req_strides_given = 0;
   logic [2:0]  req_dtype_code = 0;
   logic        req_last_dim = 0;
   logic        rsp_empty;
   logic        rsp_pop = 0;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_elem_total, rsp_byte_total, rsp_span_bytes, rsp_out_stride;
   logic        rsp_contiguous, rsp_last_result;
   logic [2:0]  rsp_dim_index;
   int          fail_count, pending_count;
   int          send_idle_pct = 0;
   int          pop_stall_pct = 0;
   bit          hold_go = 0;
   bit          hold_off = 0;
   int          idle_cycles = 0;

   tensor_layout_checker u_dut (.*);
   tensor_layout_checker_scoreboard u_scoreboard (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // receiver: random stalls, or a long counted hold-off
   always @(posedge clock) begin
      if (hold_off) rsp_pop <= 1'b0;
      else rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   always @(posedge clock) begin
      if (reset) idle_cycles <= 0;
      else if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tensor_layout_checker verification failed");
         $finish;
      end
   end

   task automatic send_dim(input logic [63:0] ext, input logic [63:0] strd,
                           input bit sg, input logic [2:0] dt, input bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_dim_extent <= ext;
      req_dim_stride <= strd;
      req_strides_given <= sg;
      req_dtype_code <= dt;
      req_last_dim <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pick_extent();
      case ($urandom_range(9))
         0: return rand64();
         1: return 64'd0;
         2: return 64'd1;
         3: return {32'd0, $urandom};
         default: return 64'($urandom_range(1, 9));
      endcase
   endfunction

   // canonical descriptor with random perturbation; strides_given on the first dim picks explicit strides
   task automatic send_descriptor(input int rank, input bit sg, input logic [2:0] dt);
      logic [63:0] exts [16];
      logic [63:0] strd [16];
      logic [63:0] canon;
      int esz;
      esz = (dt == DT_I8) ? 1 : (dt == DT_F16 || dt == DT_BF16) ? 2 : 4;
      for (int i = 0; i < rank; i++) exts[i] = pick_extent();
      canon = 64'(esz);
      for (int i = rank - 1; i >= 0; i--) begin
         case ($urandom_range(7))
            0: strd[i] = rand64();
            1: strd[i] = 0;
            2: strd[i] = canon * $urandom_range(1, 3) + $urandom_range(0, 1);
            default: strd[i] = canon;
         endcase
         canon = canon * exts[i];
      end
      for (int i = 0; i < rank; i++)
         send_dim(exts[i], strd[i], (i == 0) ? sg : 1'($urandom_range(1)),
                  (i == 0) ? dt : 3'($urandom_range(7)), i == rank - 1);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // directed descriptors
      send_dim(64'd2, 0, 0, DT_F32, 0);
      send_dim(64'd3, 0, 0, DT_F32, 1);
      send_dim(64'd5, 0, 0, DT_I8, 1);
      send_dim(64'd4, 0, 0, 3'd5, 1);
      send_dim(64'd4, 0, 0, 3'd7, 1);
      send_dim(64'd0, 0, 0, DT_F16, 1);
      send_dim('1, 0, 0, DT_I8, 0);
      send_dim(64'd2, 0, 0, DT_I8, 1);
      send_dim('1, 0, 0, DT_BF16, 1);
      send_dim(64'd3, 64'd8, 1, DT_I32, 0);
      send_dim(64'd2, 64'd4, 1, DT_I32, 1);
      send_dim(64'd3, 64'd0, 1, DT_F32, 1);
      send_dim(64'd1, 64'd0, 1, DT_F32, 1);
      send_dim(64'd3, 64'd3, 1, DT_F32, 1);
      send_dim(64'd3, '1 - 64'd1, 1, DT_F16, 1);
      for (int i = 0; i < 10; i++) send_dim(64'd1, 0, 0, DT_F32, i == 9);
      drain();
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? 53 : 0;
         send_idle_pct = (phase == 3) ? 38 : send_idle_pct;
         pop_stall_pct = (phase == 2) ? 53 : (phase == 3) ? 38 : 0;
         if (phase == 1) hold_go = 1;
         for (int k = 0; k < 11; k++) begin
            if ($urandom_range(9) == 0)
               send_descriptor($urandom_range(1, 11), 1'($urandom_range(1)),
                               3'($urandom_range(7)));
            else
               send_descriptor($urandom_range(1, 5), 1'($urandom_range(1)),
                               3'($urandom_range(4)));
         end
         drain();
      end
      if (fail_count == 0) begin
         $display("tensor_layout_checker verification clean");
      end else begin
         $display("tensor_layout_checker verification failed");
      end
      $finish;
   end

   initial begin
      // long receiver hold-off, counted in its own process
      wait (hold_go);
      hold_off <= 1'b1;
      repeat (400) @(posedge clock);
      hold_off <= 1'b0;
   end
endmodule

@@ sim.f @@
rtl/tlc_pkg.sv
rtl/tlc_front.sv
rtl/tlc_mul.sv
rtl/tlc_back.sv
rtl/tensor_layout_checker.sv
tb/tensor_layout_checker_scoreboard.sv
tb/tensor_layout_checker_tb.sv
